### sv/bpws_pkg.sv
// ----------------------------------------------------------------------------
// bpws_pkg: shared types and constants of the buffer pool
// Operation and status codes, register indexes, default sizes and the
// command record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bpws_pkg;

    // Default sizes of the pool.
    localparam int unsigned NUM_BUCKETS_DEF   = 8;
    localparam int unsigned BUCKET_DEPTH_DEF  = 64;
    localparam int unsigned ELEMENT_WIDTH_DEF = 32;
    localparam int unsigned MAX_POP_DEF       = 16;

    // Command fields are sized for the largest supported pool.
    localparam int unsigned ADDR_MAX_W  = 18;
    localparam int unsigned ELEM_MAX_W  = 64;
    localparam int unsigned CNT_MAX_W   = 7;

    // Entries of the command queue between front and back end.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Register reset values.
    localparam logic [3:0] BUCKETS_IN_USE_RST  = 4'd8;
    localparam logic [6:0] BUCKET_CAPACITY_RST = 7'd64;

    // Register indexes on the configuration port.
    localparam logic CFG_BUCKETS_IN_USE  = 1'b0;
    localparam logic CFG_BUCKET_CAPACITY = 1'b1;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PUSH    = 2'd2,
        OP_POP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_FULL    = 2'd2,
        ST_SHORT   = 2'd3
    } status_t;

    // One classified operation. A command with rd set produces count beats,
    // each reading one element; any other command produces a single beat.
    typedef struct packed {
        logic                  wr_en;
        logic                  rd;
        logic [ADDR_MAX_W-1:0] addr;
        logic [ELEM_MAX_W-1:0] wdata;
        logic [CNT_MAX_W-1:0]  count;
        status_t               status;
        logic [2:0]            granted;
        logic [6:0]            fill;
    } cmd_t;

endpackage

`default_nettype wire

### sv/buffer_pool_with_stacks_top.sv
// Path: a result beat goes from its input beat through the command queue and the registered
// output stage of the back end; a pop of n elements gives n beats.
// Throughput: one input beat per cycle while the four-entry command queue has room; results
// leave at one beat per cycle while m_tready is high, paced by the single element RAM read port.
// Reset: aresetn (synchronous, active low) frees every bucket, zeroes all fill levels and
// restores buckets_in_use to 8 and bucket_capacity to 64; element storage is not cleared.
// ----------------------------------------------------------------------------
// buffer_pool_with_stacks_top: fixed-size bucket pool with per-bucket stacks
// Acquire, release, push and pop on a pool of buckets, each a small stack
// of elements. Decisions are made at the input, execution at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_with_stacks_top #(
    parameter int unsigned NUM_BUCKETS   = bpws_pkg::NUM_BUCKETS_DEF,
    parameter int unsigned BUCKET_DEPTH  = bpws_pkg::BUCKET_DEPTH_DEF,
    parameter int unsigned ELEMENT_WIDTH = bpws_pkg::ELEMENT_WIDTH_DEF,
    parameter int unsigned MAX_POP       = bpws_pkg::MAX_POP_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input beats.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] op, [4:2] bucket, [9:5] count, [41:10] write_data, [47:42] zero
    input  wire logic [47:0] s_tdata,

    // Result beats.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [4:2] granted_bucket, [36:5] read_data, [43:37] fill,
    // [47:44] zero
    output logic [47:0]      m_tdata,
    output logic             m_tlast,

    // Register writes: index 0 buckets_in_use, index 1 bucket_capacity.
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [6:0]  cfg_wdata
);

    import bpws_pkg::*;

    // Front end to queue.
    cmd_t    fe_cmd;
    logic    fe_push;
    logic    q_full;

    // Queue to back end.
    cmd_t    q_head;
    logic    q_valid;
    logic    q_pop;

    // Back end result fields.
    status_t be_status;
    logic [2:0]  be_granted;
    logic [31:0] be_read_data;
    logic [6:0]  be_fill;

    // The front end owns all bookkeeping: taken flags, fill levels and the
    // two configuration registers. Every operation is resolved in the cycle
    // it is accepted, so the next beat always sees up-to-date state and
    // the back end never has to feed anything back.
    bpws_front #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .BUCKET_DEPTH  (BUCKET_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .MAX_POP       (MAX_POP)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tdata[1:0]),
        .in_bucket     (s_tdata[4:2]),
        .in_count      (s_tdata[9:5]),
        .in_write_data (s_tdata[41:10]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .q_push        (fe_push),
        .q_cmd         (fe_cmd)
    );

    // Commands wait here while the back end works through a multi-beat pop
    // or the result side is stalled.
    bpws_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (fe_push),
        .wr_cmd    (fe_cmd),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_cmd    (q_head),
        .not_empty (q_valid)
    );

    // The back end performs element writes for pushes and element reads for
    // pops in queue order, so a pop always sees the data of earlier pushes.
    bpws_back #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .BUCKET_DEPTH  (BUCKET_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .MAX_POP       (MAX_POP)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_valid),
        .head_cmd      (q_head),
        .head_pop      (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (be_status),
        .out_granted   (be_granted),
        .out_read_data (be_read_data),
        .out_fill      (be_fill),
        .out_last      (m_tlast)
    );

    assign m_tdata = {4'd0, be_fill, be_read_data, be_granted, be_status};

endmodule

`default_nettype wire

### sv/bpws_ram.sv
// ----------------------------------------------------------------------------
// bpws_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpws_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 512,
    parameter int unsigned ADDR_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/bpws_front.sv
// ----------------------------------------------------------------------------
// bpws_front: operation classifier and bookkeeping
// Holds the configuration registers, taken flags and fill levels, decides
// each operation at acceptance and hands a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpws_front #(
    parameter int unsigned NUM_BUCKETS   = 8,
    parameter int unsigned BUCKET_DEPTH  = 64,
    parameter int unsigned ELEMENT_WIDTH = 32,
    parameter int unsigned MAX_POP       = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_op,
    input  wire logic [2:0]        in_bucket,
    input  wire logic [4:0]        in_count,
    input  wire logic [31:0]       in_write_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [6:0]        cfg_wdata,
    input  wire logic              q_full,
    output logic                   q_push,
    output bpws_pkg::cmd_t         q_cmd
);

    import bpws_pkg::*;

    localparam int unsigned NB_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned IX_W   = ((NB_W > 3) ? NB_W : 3) + 1;
    localparam int unsigned LW     = ($clog2(NUM_BUCKETS + 1) > 4) ?
                                     $clog2(NUM_BUCKETS + 1) : 4;
    localparam int unsigned FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int unsigned CMP_W  = (FILL_W > 7) ? FILL_W : 7;
    localparam int unsigned CNT_W  = $clog2(MAX_POP + 1);
    localparam int unsigned CC_W   = (CNT_W > 5) ? CNT_W : 5;
    localparam int unsigned FC_W   = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam int unsigned ADDR_W = (NUM_BUCKETS * BUCKET_DEPTH > 1) ?
                                     $clog2(NUM_BUCKETS * BUCKET_DEPTH) : 1;

    logic [3:0]              biu_reg;
    logic [6:0]              cap_reg;
    logic [NUM_BUCKETS-1:0]  taken_reg;
    logic [FILL_W-1:0]       fill_reg [NUM_BUCKETS];

    op_t                     op;
    logic [IX_W-1:0]         bucket_ext;
    logic [NB_W-1:0]         b_ix;
    logic                    b_ok;
    logic                    found;
    logic [NB_W-1:0]         grant_ix;
    logic [NB_W-1:0]         sel_ix;
    logic [FILL_W-1:0]       fill_cur;
    logic [CMP_W-1:0]        cap_eff;
    logic                    is_full;
    logic [CC_W-1:0]         cnt_ext;
    logic [CNT_W-1:0]        cnt_sat;
    logic                    is_short;
    logic [FILL_W-1:0]       new_fill;
    logic [ADDR_W-1:0]       base_addr;
    logic                    take;
    logic                    rel;
    logic                    fill_we;
    logic [FILL_W-1:0]       fill_next;
    logic                    accept;

    assign op         = op_t'(in_op);
    assign bucket_ext = IX_W'(in_bucket);
    assign b_ix       = bucket_ext[NB_W-1:0];
    assign b_ok       = bucket_ext < IX_W'(NUM_BUCKETS);

    // Lowest free bucket among those in use.
    always_comb begin
        found    = 1'b0;
        grant_ix = '0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
            if (!taken_reg[i] && (LW'(i) < LW'(biu_reg))) begin
                found    = 1'b1;
                grant_ix = NB_W'(i);
            end
        end
    end

    assign sel_ix    = (op == OP_ACQUIRE) ? grant_ix : b_ix;
    assign fill_cur  = fill_reg[sel_ix];
    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(BUCKET_DEPTH)) ?
                       CMP_W'(BUCKET_DEPTH) : CMP_W'(cap_reg);
    assign is_full   = CMP_W'(fill_cur) >= cap_eff;
    assign cnt_ext   = CC_W'(in_count);
    assign cnt_sat   = (cnt_ext > CC_W'(MAX_POP)) ? CNT_W'(MAX_POP) : CNT_W'(cnt_ext);
    assign is_short  = FC_W'(fill_cur) < FC_W'(cnt_sat);
    assign new_fill  = FILL_W'(FC_W'(fill_cur) - FC_W'(cnt_sat));
    assign base_addr = ADDR_W'(ADDR_W'(sel_ix) * ADDR_W'(BUCKET_DEPTH));

    always_comb begin
        q_cmd        = '0;
        q_cmd.status = ST_OK;
        take         = 1'b0;
        rel          = 1'b0;
        fill_we      = 1'b0;
        fill_next    = fill_cur;
        unique case (op)
            OP_ACQUIRE: begin
                if (found) begin
                    take          = 1'b1;
                    q_cmd.granted = 3'(grant_ix);
                    q_cmd.fill    = 7'(fill_cur);
                end else begin
                    q_cmd.status  = ST_NO_FREE;
                end
            end
            OP_RELEASE: begin
                if (b_ok) begin
                    rel        = 1'b1;
                    q_cmd.fill = 7'(fill_cur);
                end
            end
            OP_PUSH: begin
                if (!b_ok) begin
                    q_cmd.status = ST_FULL;
                end else if (is_full) begin
                    q_cmd.status = ST_FULL;
                    q_cmd.fill   = 7'(fill_cur);
                end else begin
                    fill_we      = 1'b1;
                    fill_next    = FILL_W'(fill_cur + 1'b1);
                    q_cmd.wr_en  = 1'b1;
                    q_cmd.addr   = ADDR_MAX_W'(base_addr + ADDR_W'(fill_cur));
                    q_cmd.wdata  = ELEM_MAX_W'(ELEMENT_WIDTH'(in_write_data));
                    q_cmd.fill   = 7'(FILL_W'(fill_cur + 1'b1));
                end
            end
            OP_POP: begin
                if (!b_ok) begin
                    q_cmd.status = ST_SHORT;
                end else if (is_short) begin
                    q_cmd.status = ST_SHORT;
                    q_cmd.fill   = 7'(fill_cur);
                end else if (cnt_sat == '0) begin
                    q_cmd.fill   = 7'(fill_cur);
                end else begin
                    fill_we      = 1'b1;
                    fill_next    = new_fill;
                    q_cmd.rd     = 1'b1;
                    q_cmd.addr   = ADDR_MAX_W'(base_addr + ADDR_W'(new_fill));
                    q_cmd.count  = CNT_MAX_W'(cnt_sat);
                    q_cmd.fill   = 7'(new_fill);
                end
            end
            default: begin
                q_cmd.status = ST_OK;
            end
        endcase
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            biu_reg   <= BUCKETS_IN_USE_RST;
            cap_reg   <= BUCKET_CAPACITY_RST;
            taken_reg <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BUCKETS_IN_USE:  biu_reg <= cfg_wdata[3:0];
                    CFG_BUCKET_CAPACITY: cap_reg <= cfg_wdata;
                    default:             cap_reg <= cap_reg;
                endcase
            end
            if (accept) begin
                if (take) begin
                    taken_reg[grant_ix] <= 1'b1;
                end
                if (rel) begin
                    taken_reg[b_ix] <= 1'b0;
                end
                if (fill_we) begin
                    fill_reg[b_ix] <= fill_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/bpws_queue.sv
// ----------------------------------------------------------------------------
// bpws_queue: command queue between front and back end
// A small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bpws_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire bpws_pkg::cmd_t wr_cmd,
    output logic                full,
    input  wire logic           rd_en,
    output bpws_pkg::cmd_t      rd_cmd,
    output logic                not_empty
);

    import bpws_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   level_reg;
    logic             do_wr;
    logic             do_rd;

    assign full      = level_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = level_reg != '0;
    assign rd_cmd    = entry_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                level_reg <= level_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/bpws_back.sv
// ----------------------------------------------------------------------------
// bpws_back: element store and result sequencer
// Executes queued commands against the element RAM and emits one result
// beat per cycle through a registered output stage while out_ready does not stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpws_back #(
    parameter int unsigned NUM_BUCKETS   = 8,
    parameter int unsigned BUCKET_DEPTH  = 64,
    parameter int unsigned ELEMENT_WIDTH = 32,
    parameter int unsigned MAX_POP       = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           head_valid,
    input  wire bpws_pkg::cmd_t head_cmd,
    output logic                head_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bpws_pkg::status_t   out_status,
    output logic [2:0]          out_granted,
    output logic [31:0]         out_read_data,
    output logic [6:0]          out_fill,
    output logic                out_last
);

    import bpws_pkg::*;

    localparam int unsigned DEPTH  = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_POP + 1);

    logic [CNT_W-1:0]         beat_reg;
    logic                     valid_reg;
    status_t                  status_reg;
    logic [2:0]               granted_reg;
    logic [6:0]               fill_reg;
    logic                     last_reg;
    logic                     rdsel_reg;

    logic                     advance;
    logic                     issue;
    logic                     beat_last;
    logic [ADDR_W-1:0]        head_addr;
    logic [ELEMENT_WIDTH-1:0] ram_q;

    // The output stage moves whenever it is empty or being drained; the RAM
    // read register only updates on a move, so it holds under backpressure.
    assign advance   = !valid_reg || out_ready;
    assign issue     = advance && head_valid;
    assign beat_last = !head_cmd.rd ||
                       ((CNT_W + 1)'(beat_reg) + 1'b1 ==
                        (CNT_W + 1)'(head_cmd.count[CNT_W-1:0]));
    assign head_pop  = issue && beat_last;
    assign head_addr = head_cmd.addr[ADDR_W-1:0];

    bpws_ram #(
        .WIDTH  (ELEMENT_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (issue && head_cmd.wr_en),
        .waddr (head_addr),
        .wdata (head_cmd.wdata[ELEMENT_WIDTH-1:0]),
        .re    (issue && head_cmd.rd),
        .raddr (head_addr + ADDR_W'(beat_reg)),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                beat_reg <= beat_last ? '0 : beat_reg + 1'b1;
            end
            if (advance) begin
                valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            status_reg  <= head_cmd.status;
            granted_reg <= head_cmd.granted;
            fill_reg    <= head_cmd.fill;
            last_reg    <= beat_last;
            rdsel_reg   <= head_cmd.rd;
        end
    end

    assign out_valid     = valid_reg;
    assign out_status    = status_reg;
    assign out_granted   = granted_reg;
    assign out_fill      = fill_reg;
    assign out_last      = last_reg;
    assign out_read_data = rdsel_reg ? 32'(ram_q) : 32'd0;

endmodule

`default_nettype wire

### sv/bpws_checker.sv
// ----------------------------------------------------------------------------
// bpws_checker: port-level checks of the buffer pool
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpws_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);

    import bpws_pkg::*;

    // No result beat is shown in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

    // A failed operation ends with a single beat carrying no element.
    a_fail_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tlast && (m_tdata[36:5] == 32'd0)))
        else $error("failed operation gave more than one beat or data");

    // Beats inside a pop run are successful and grant nothing.
    a_run_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[4:0] == 5'd0))
        else $error("non-final beat with status or grant set");

endmodule

bind buffer_pool_with_stacks_top bpws_checker u_bpws_checker (.*);

`default_nettype wire
